FILE: rtl/hps_pkg.sv
// Package for the quadratic-probe hash set: payload structs, codes, constants
// and the key hash function. No dependencies.
`timescale 1ns / 1ps

package hps_pkg;

  localparam int KEY_W      = 32;
  localparam int SLOT_W     = 7;
  localparam int DIGIT_W    = 8;
  localparam int NUM_DIGITS = KEY_W / DIGIT_W;
  localparam int DCNT_W     = $clog2(NUM_DIGITS);

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_CLEAR  = 2'd3
  } hps_action_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_DUP      = 2'd1,
    STATUS_NOTFOUND = 2'd2,
    STATUS_FULL     = 2'd3
  } hps_status_t;

  // Slot mark; the fourth code is never written
  typedef enum logic [1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_ACTIVE  = 2'd1,
    MARK_DELETED = 2'd2
  } hps_mark_t;

  typedef enum logic [2:0] {
    ST_INIT  = 3'd0,
    ST_IDLE  = 3'd1,
    ST_PROBE = 3'd2,
    ST_CHECK = 3'd3,
    ST_CLEAR = 3'd4
  } hps_state_t;

  typedef struct packed {
    logic [1:0]       action;
    logic [KEY_W-1:0] key;
  } hps_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
  } hps_rsp_t;

  // Shift-xor hash over the key bytes, low byte first, each sign-extended
  function automatic logic [KEY_W-1:0] hps_hash(input logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] h;
    logic [KEY_W-1:0] b;
    h = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      b = {{(KEY_W-DIGIT_W){key[DIGIT_W*i+DIGIT_W-1]}}, key[DIGIT_W*i +: DIGIT_W]};
      h = (h << 5) ^ b ^ h;
    end
    return h;
  endfunction

endpackage

FILE: rtl/hps_fifo.sv
// Two-entry queue between the hash front end and the probe back end.
// Standalone; width set by the parent.
`timescale 1ns / 1ps

module hps_fifo #(
  parameter int WIDTH = 41
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] entry [2];
  logic             wp;
  logic             rp;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entry[rp];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop)  rp <= ~rp;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) entry[wp] <= wdata;
  end

endmodule

FILE: rtl/hps_front.sv
// Front end: accepts a request, hashes the key and reduces it to a home slot
// one byte per cycle, then hands the item to the queue. Uses hps_pkg.
`timescale 1ns / 1ps

module hps_front import hps_pkg::*; #(
  parameter  int TABLE_SIZE = 101,
  localparam int SW = $clog2(TABLE_SIZE)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  hps_req_t         req,
  output logic             full,
  input  logic             init_busy,
  output logic             q_push,
  input  logic             q_full,
  output logic [1:0]       q_action,
  output logic [KEY_W-1:0] q_key,
  output logic [SW-1:0]    q_home
);

  localparam logic [SW:0] MOD = (SW+1)'(TABLE_SIZE);

  logic              busy;
  logic              done;
  logic [DCNT_W-1:0] cnt;
  logic [KEY_W-1:0]  hreg;
  logic [SW-1:0]     rem;
  logic [SW-1:0]     rem_next;
  logic [1:0]        act;
  logic [KEY_W-1:0]  key;
  logic              accept;

  assign full     = init_busy || (busy && !(done && !q_full));
  assign accept   = push && !full;
  assign q_push   = busy && done && !q_full;
  assign q_action = act;
  assign q_key    = key;
  assign q_home   = rem;

  // Shift the top hash byte into the remainder, reducing bit by bit
  always_comb begin
    logic [SW:0] w;
    logic [SW-1:0] t;
    t = rem;
    for (int i = 0; i < DIGIT_W; i++) begin
      w = {t, hreg[KEY_W-1-i]};
      if (w >= MOD) w = w - MOD;
      t = w[SW-1:0];
    end
    rem_next = t;
  end

  // Sequence the digit steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (q_push) begin
      busy <= 1'b0;
    end else if (busy && !done) begin
      cnt  <= cnt + 1'b1;
      done <= (cnt == DCNT_W'(NUM_DIGITS - 1));
    end
  end

  // Capture the request and walk the hash bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      hreg <= hps_hash(req.key);
      rem  <= '0;
      act  <= req.action;
      key  <= req.key;
    end else if (busy && !done) begin
      hreg <= hreg << DIGIT_W;
      rem  <= rem_next;
    end
  end

endmodule

FILE: rtl/hps_back.sv
// Back end: takes hashed items from the queue, probes the slot memory,
// updates marks and keys, sweeps the table on clear and after reset. Uses hps_pkg.
`timescale 1ns / 1ps

module hps_back import hps_pkg::*; #(
  parameter  int TABLE_SIZE = 101,
  localparam int SW = $clog2(TABLE_SIZE)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  logic [1:0]       q_action,
  input  logic [KEY_W-1:0] q_key,
  input  logic [SW-1:0]    q_home,
  output logic             q_pop,
  output logic             init_busy,
  input  logic             pop,
  output logic             empty,
  output hps_rsp_t         rsp
);

  localparam int CW = $clog2(TABLE_SIZE + 1);
  localparam int UW = $clog2(TABLE_SIZE / 2 + 1);
  localparam logic [SW:0] MOD = (SW+1)'(TABLE_SIZE);

  // Slot memories
  logic [KEY_W-1:0] keys  [TABLE_SIZE];
  logic [1:0]       marks [TABLE_SIZE];
  logic [KEY_W-1:0] key_q;
  logic [1:0]       mark_q;

  hps_state_t       state;
  hps_state_t       state_next;
  logic [SW-1:0]    pos;
  logic [SW-1:0]    step;
  logic [CW-1:0]    pcount;
  logic [1:0]       act;
  logic [KEY_W-1:0] key;
  logic [UW-1:0]    used;
  logic             res_valid;
  hps_rsp_t         res;

  logic          res_free;
  logic          last_idx;
  logic          hit;
  logic          active;
  logic          finish;
  logic          room;
  logic [SW:0]   pos_sum;
  logic [SW:0]   step_sum;
  logic [SW-1:0] nxt_pos;
  logic [SW-1:0] step_next;
  logic [SW-1:0] end_pos;

  logic          we_key;
  logic          we_mark;
  logic [1:0]    mark_wval;
  logic          fin;
  hps_rsp_t      fin_rsp;
  logic          used_inc;
  logic          used_clr;

  assign init_busy = (state == ST_INIT);
  assign empty     = !res_valid;
  assign rsp       = res;
  assign res_free  = !res_valid || pop;
  assign last_idx  = (pos == SW'(TABLE_SIZE - 1));

  // Probe evaluation and next probe position
  assign hit       = (mark_q == MARK_EMPTY) || (key_q == key);
  assign active    = hit && (mark_q == MARK_ACTIVE);
  assign finish    = hit || (pcount == CW'(TABLE_SIZE));
  assign room      = (used < UW'(TABLE_SIZE / 2));
  assign pos_sum   = {1'b0, pos} + {1'b0, step};
  assign nxt_pos   = (pos_sum >= MOD) ? SW'(pos_sum - MOD) : pos_sum[SW-1:0];
  assign step_sum  = {1'b0, step} + (SW+1)'(2);
  assign step_next = (step_sum >= MOD) ? SW'(step_sum - MOD) : step_sum[SW-1:0];
  assign end_pos   = hit ? pos : nxt_pos;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT:  if (last_idx) state_next = ST_IDLE;
      ST_IDLE: begin
        if (!q_empty) state_next = (q_action == ACT_CLEAR) ? ST_CLEAR : ST_PROBE;
      end
      ST_PROBE: state_next = ST_CHECK;
      ST_CHECK: begin
        if (!finish)       state_next = ST_PROBE;
        else if (res_free) state_next = ST_IDLE;
      end
      ST_CLEAR: if (last_idx && res_free) state_next = ST_IDLE;
      default:  state_next = ST_INIT;
    endcase
  end

  // Outputs: queue pop, memory writes, result load
  always_comb begin
    q_pop          = 1'b0;
    we_key         = 1'b0;
    we_mark        = 1'b0;
    mark_wval      = MARK_EMPTY;
    fin            = 1'b0;
    fin_rsp.status = STATUS_OK;
    fin_rsp.slot   = SLOT_W'(end_pos);
    used_inc       = 1'b0;
    used_clr       = 1'b0;
    case (state)
      ST_INIT:  we_mark = 1'b1;
      ST_IDLE:  q_pop = !q_empty;
      ST_PROBE: ;
      ST_CHECK: begin
        if (finish && res_free) begin
          fin = 1'b1;
          case (act)
            ACT_INSERT: begin
              if (active) begin
                fin_rsp.status = STATUS_DUP;
              end else if (!hit || !room) begin
                fin_rsp.status = STATUS_FULL;
              end else begin
                we_key    = 1'b1;
                we_mark   = 1'b1;
                mark_wval = MARK_ACTIVE;
                used_inc  = 1'b1;
              end
            end
            ACT_REMOVE: begin
              if (active) begin
                we_mark   = 1'b1;
                mark_wval = MARK_DELETED;
              end else begin
                fin_rsp.status = STATUS_NOTFOUND;
              end
            end
            default: begin
              if (!active) fin_rsp.status = STATUS_NOTFOUND;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        we_mark = 1'b1;
        if (last_idx && res_free) begin
          fin          = 1'b1;
          fin_rsp.slot = '0;
          used_clr     = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control and item registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      pos       <= '0;
      used      <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_INIT, ST_CLEAR: if (!last_idx) pos <= pos + 1'b1;
        ST_IDLE: begin
          if (q_pop) begin
            pos    <= (q_action == ACT_CLEAR) ? '0 : q_home;
            step   <= SW'(1);
            pcount <= CW'(1);
            act    <= q_action;
            key    <= q_key;
          end
        end
        ST_CHECK: begin
          if (!finish) begin
            pos    <= nxt_pos;
            step   <= step_next;
            pcount <= pcount + 1'b1;
          end
        end
        default: ;
      endcase
      if (used_clr)      used <= '0;
      else if (used_inc) used <= used + 1'b1;
      if (fin)           res_valid <= 1'b1;
      else if (pop)      res_valid <= 1'b0;
      if (fin)           res <= fin_rsp;
    end
  end

  // Slot memory: one write and one registered read at the probe position
  always_ff @(posedge clk) begin
    if (we_key)  keys[pos]  <= key;
    if (we_mark) marks[pos] <= mark_wval;
    key_q  <= keys[pos];
    mark_q <= marks[pos];
  end

endmodule

FILE: rtl/quadratic_probe_hash_set_unit.sv
// Quadratic-probe hash set, top level: hash front end, work queue, probe back end.
// Uses hps_pkg, hps_front, hps_fifo and hps_back.
//
//   channel   handshake               payload
//   request   push / full             req.action, req.key   (hps_req_t)
//   result    empty / pop             rsp.status, rsp.slot  (hps_rsp_t)
//
// Front end: takes the request and registers its hash, then reduces the hash
// modulo TABLE_SIZE one key byte at a time and hands off to a two-entry queue.
// Back end: dequeues in the idle state, then probes via a memory read state and a
// check state; a clear sweeps the marks one slot per cycle, waiting on the last
// slot until the result port is free. After reset the sweep runs with full held high.
// A waiting result stalls only the back end; the front end keeps filling the queue.
`timescale 1ns / 1ps

module quadratic_probe_hash_set_unit import hps_pkg::*; #(
  parameter int TABLE_SIZE = 101
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  hps_req_t req,
  output logic     full,
  output logic     empty,
  input  logic     pop,
  output hps_rsp_t rsp
);

  localparam int SW = $clog2(TABLE_SIZE);
  localparam int QW = 2 + KEY_W + SW;

  logic             init_busy;
  logic             q_push;
  logic             q_full;
  logic [1:0]       q_action;
  logic [KEY_W-1:0] q_key;
  logic [SW-1:0]    q_home;
  logic [QW-1:0]    q_rdata;
  logic             q_pop;
  logic             q_empty;

  hps_front #(.TABLE_SIZE(TABLE_SIZE)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .req       (req),
    .full      (full),
    .init_busy (init_busy),
    .q_push    (q_push),
    .q_full    (q_full),
    .q_action  (q_action),
    .q_key     (q_key),
    .q_home    (q_home)
  );

  hps_fifo #(.WIDTH(QW)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata ({q_action, q_key, q_home}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  hps_back #(.TABLE_SIZE(TABLE_SIZE)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_action  (q_rdata[QW-1 -: 2]),
    .q_key     (q_rdata[SW +: KEY_W]),
    .q_home    (q_rdata[SW-1:0]),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .pop       (pop),
    .empty     (empty),
    .rsp       (rsp)
  );

`ifndef ASSERT_OFF
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full) else $error("front pushed into a full queue");

  a_home_in_range: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_home < SW'(TABLE_SIZE))) else $error("home slot out of range");

  a_no_accept_in_init: assert property (@(posedge clk)
    init_busy |-> full) else $error("request port open during reset sweep");

  a_front_holds_item: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> full) else $error("front accepted while hashing");
`endif

endmodule
